// File: design/ris_pkg.sv
`timescale 1ns / 1ps

package ris_pkg;

	// default list capacity
	localparam int LIST_DEPTH_DEF = 16;

	// field widths
	localparam int ID_W   = 32;
	localparam int NAME_W = 64;
	localparam int POS_W  = 4;

	// one stored record
	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic [NAME_W-1:0]      name_key;
	} rec_t;

	// input action codes
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_SORT  = 2'd2
	} action_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ENTRY = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_FULL  = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLAG,
		ST_LOAD_KEY,
		ST_COMPARE,
		ST_EMIT_READ,
		ST_EMIT_OUT
	} state_t;

endpackage

// File: design/record_insertion_sort.sv
`timescale 1ns / 1ps

// Record list with stable insertion sort. Clear and add items are handled in
// the idle state (an add to a full list produces one flag result). A sort item
// of n records runs on one comparator and a record memory with one write and
// one registered read port: each key shifts larger left neighbours right, at
// most n*(n-1)/2 record shifts in all, then the list gives one result per
// cycle while the output side takes them. A sort of an empty list gives one
// empty marker. The sorted order stays in the list for later sorts. Results
// sit in an output register, so a new item is taken while one still waits.
module record_insertion_sort #(
	parameter int LIST_DEPTH = ris_pkg::LIST_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic signed [ris_pkg::ID_W-1:0]   id,
	input  logic [ris_pkg::NAME_W-1:0]        name_key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic signed [ris_pkg::ID_W-1:0]   id_res,
	output logic [ris_pkg::NAME_W-1:0]        name_key_res,
	output logic [ris_pkg::POS_W-1:0]         position,
	output logic                              last
);
	import ris_pkg::*;

	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	state_t             state_q, state_d;
	logic               sort_key_select_q;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   i_q, i_d;
	logic [IDX_W-1:0]   j_q, j_d;
	logic [IDX_W-1:0]   k_q, k_d;
	rec_t               key_q, key_d;
	kind_t              flag_kind_q, flag_kind_d;

	logic               mem_wr_en;
	logic [IDX_W-1:0]   mem_wr_addr;
	rec_t               mem_wr_data;
	logic               mem_rd_en;
	logic [IDX_W-1:0]   mem_rd_addr;
	rec_t               mem_rd_data;
	logic               key_less;

	logic               out_valid_q;
	kind_t              kind_q;
	rec_t               rec_q;
	logic [POS_W-1:0]   pos_q;
	logic               last_q;

	logic               out_load;
	kind_t              out_kind;
	rec_t               out_rec;
	logic [POS_W-1:0]   out_pos;
	logic               out_last;
	logic               slot_free;
	logic               k_last;

	ris_mem #(
		.DEPTH(LIST_DEPTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// shared comparator: held key against the record just read
	ris_cmp u_cmp (
		.sel_name(sort_key_select_q),
		.a       (key_q),
		.b       (mem_rd_data),
		.a_less  (key_less)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign k_last    = (CNT_W'(k_q) + 1'b1) == count_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_select_q <= 1'b0;
		end else if (cfg_wr_en) begin
			sort_key_select_q <= cfg_wr_data;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// loop indices, held key and flag kind
	always_ff @(posedge clk) begin
		i_q         <= i_d;
		j_q         <= j_d;
		k_q         <= k_d;
		key_q       <= key_d;
		flag_kind_q <= flag_kind_d;
	end

	// next state and controls
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		key_d       = key_q;
		flag_kind_d = flag_kind_q;
		in_ready    = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = j_q;
		mem_wr_data = key_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = k_q;
		out_load    = 1'b0;
		out_kind    = KIND_ENTRY;
		out_rec     = mem_rd_data;
		out_pos     = POS_W'(k_q);
		out_last    = k_last;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						ACT_CLEAR: begin
							count_d = '0;
						end
						ACT_ADD: begin
							if (count_q == CNT_W'(LIST_DEPTH)) begin
								flag_kind_d = KIND_FULL;
								state_d     = ST_FLAG;
							end else begin
								mem_wr_en     = 1'b1;
								mem_wr_addr   = count_q[IDX_W-1:0];
								mem_wr_data.id       = id;
								mem_wr_data.name_key = name_key;
								count_d       = count_q + 1'b1;
							end
						end
						ACT_SORT: begin
							if (count_q == '0) begin
								flag_kind_d = KIND_EMPTY;
								state_d     = ST_FLAG;
							end else if (count_q == CNT_W'(1)) begin
								k_d     = '0;
								state_d = ST_EMIT_READ;
							end else begin
								i_d         = IDX_W'(1);
								mem_rd_en   = 1'b1;
								mem_rd_addr = IDX_W'(1);
								state_d     = ST_LOAD_KEY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FLAG: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_kind = flag_kind_q;
					out_rec  = '0;
					out_pos  = '0;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_LOAD_KEY: begin
				// take record i as the key, fetch its left neighbour
				key_d       = mem_rd_data;
				j_d         = i_q;
				mem_rd_en   = 1'b1;
				mem_rd_addr = i_q - 1'b1;
				state_d     = ST_COMPARE;
			end
			ST_COMPARE: begin
				mem_wr_en = 1'b1;
				if (j_q != '0 && key_less) begin
					// shift neighbour right, fetch the next one down
					mem_wr_addr = j_q;
					mem_wr_data = mem_rd_data;
					j_d         = j_q - 1'b1;
					mem_rd_en   = 1'b1;
					mem_rd_addr = j_q - IDX_W'(2);
				end else begin
					// drop the key into its slot
					mem_wr_addr = j_q;
					mem_wr_data = key_q;
					if ((CNT_W'(i_q) + 1'b1) == count_q) begin
						k_d     = '0;
						state_d = ST_EMIT_READ;
					end else begin
						i_d         = i_q + 1'b1;
						mem_rd_en   = 1'b1;
						mem_rd_addr = i_q + 1'b1;
						state_d     = ST_LOAD_KEY;
					end
				end
			end
			ST_EMIT_READ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = k_q;
				state_d     = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (k_last) begin
						state_d = ST_IDLE;
					end else begin
						k_d         = k_q + 1'b1;
						mem_rd_en   = 1'b1;
						mem_rd_addr = k_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= out_kind;
			rec_q  <= out_rec;
			pos_q  <= out_pos;
			last_q <= out_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign id_res       = rec_q.id;
	assign name_key_res = rec_q.name_key;
	assign position     = pos_q;
	assign last         = last_q;

endmodule

// File: design/ris_mem.sv
`timescale 1ns / 1ps

module ris_mem #(
	parameter int DEPTH = ris_pkg::LIST_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  ris_pkg::rec_t              wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output ris_pkg::rec_t              rd_data
);
	import ris_pkg::*;

	rec_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/ris_cmp.sv
`timescale 1ns / 1ps

module ris_cmp (
	input  logic          sel_name,
	input  ris_pkg::rec_t a,
	input  ris_pkg::rec_t b,
	output logic          a_less
);
	import ris_pkg::*;

	// strict less-than on the chosen key: signed id or unsigned name
	always_comb begin
		if (sel_name) begin
			a_less = a.name_key < b.name_key;
		end else begin
			a_less = $signed(a.id) < $signed(b.id);
		end
	end

endmodule
